>>> src/trz_pkg.sv
// ----------------------------------------------------------------------------
// Triangle rasteriser package
// Shared types, codes and default sizes for the edge-function rasteriser
// with its depth buffer.
// ----------------------------------------------------------------------------
package trz_pkg;

   // Default sizes of the design.
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_DEPTH_BITS = 16;

   // Configuration register indexes.
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'd1;
   localparam int CSR_DATA_BITS = 9;
   localparam logic [CSR_DATA_BITS-1:0] CSR_SIZE_RESET = 9'd256;

   // Operation selector codes.
   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_SCAN  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // One request.
   typedef struct packed {
      logic [1:0]         func;
      logic signed [15:0] vx0;
      logic signed [15:0] vy0;
      logic signed [15:0] vz0;
      logic signed [15:0] vx1;
      logic signed [15:0] vy1;
      logic signed [15:0] vz1;
      logic signed [15:0] vx2;
      logic signed [15:0] vy2;
      logic signed [15:0] vz2;
   } req_type;

   // One response.
   typedef struct packed {
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic [7:0] gray_level;
      logic       pixel_written;
      logic       scan_done;
      logic       degenerate;
      logic       clear_done;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_MAPX,
      ST_MAPY,
      ST_EDGE,
      ST_AREA,
      ST_FLIP,
      ST_ROW,
      ST_DIV,
      ST_SCAN0,
      ST_SCAN1,
      ST_SCAN2,
      ST_SCAN3,
      ST_CLEAR,
      ST_OUT
   } state_type;

endpackage

>>> src/trz_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module trz_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> src/triangle_raster_zbuffer.sv
// ----------------------------------------------------------------------------
// Triangle rasteriser with depth buffer
// Loads a triangle, scans its bounding box one pixel per request with a
// depth test against a buffer in RAM, and clears buffer entries one by one.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Direction
//  request   req_valid, req_stall, req_data in (stall out)
//  response  rsp_valid, rsp_stall, rsp_data out (stall in)
//  config    csr_wen, csr_index, csr_wdata  in
//
// A load passes through the map, edge, area and orientation states and then
// the divider that forms the inverse area; a zero area skips the divider. A
// scan of a pixel that passes the edge test goes on through the depth read,
// barycentric multiplies and write-back; when it fails it stops after the
// edge test, and when nothing is left to scan it goes straight to the
// response. A clear writes one entry. After reset a clearing pass writes
// MAX_WIDTH*MAX_HEIGHT entries, one per cycle, with req_stall high. A new request is taken while a response waits.
// ----------------------------------------------------------------------------
module triangle_raster_zbuffer #(
   parameter int MAX_WIDTH  = trz_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = trz_pkg::DEF_MAX_HEIGHT,
   parameter int DEPTH_BITS = trz_pkg::DEF_DEPTH_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  trz_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output trz_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wen,
   input  logic [trz_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [trz_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   import trz_pkg::*;

   localparam int WB    = $clog2(MAX_WIDTH + 1);
   localparam int HB    = $clog2(MAX_HEIGHT + 1);
   localparam int CB    = ((WB > HB) ? WB : HB) + 1;
   localparam int PB    = 2 * CB;
   localparam int AB    = PB + 2;
   localparam int EB    = PB + 4;
   localparam int MB    = EB + 18;
   localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
   localparam int IDXB  = $clog2(STORE);
   localparam int UP    = (DEPTH_BITS >= 16) ? DEPTH_BITS - 16 : 0;
   localparam int DN    = (DEPTH_BITS < 16) ? 16 - DEPTH_BITS : 0;
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
   localparam logic [IDXB-1:0] LAST_IDX = IDXB'(STORE - 1);
   localparam logic [WB-1:0]   LAST_COL = WB'(MAX_WIDTH - 1);

   state_type state_ff, state_in;

   req_type req_ff;
   rsp_type res_ff, rsp_ff;
   logic    rsp_valid_ff;

   logic [CSR_DATA_BITS-1:0] wdt_ff, hgt_ff;
   logic [WB-1:0] weff;
   logic [HB-1:0] heff;

   // Triangle setup.
   logic [WB-1:0]             sx_ff [3];
   logic [HB-1:0]             sy_ff [3];
   logic signed [15:0]        zv_ff [3];
   logic signed [CB:0]        ea_ff [3];
   logic signed [CB:0]        eb_ff [3];
   logic signed [PB-1:0]      cc_ff [3];
   logic signed [AB-1:0]      area_ff;
   logic [WB-1:0]             mnx_ff, mxx_ff;
   logic [HB-1:0]             mny_ff, mxy_ff;
   logic                      empty_ff;
   logic signed [EB-1:0]      rowv_ff [3];
   logic signed [EB-1:0]      colv_ff [3];

   // Divider.
   logic [AB:0]   rem_ff;
   logic [AB-1:0] dvs_ff;
   logic [30:0]   quo_ff;
   logic [4:0]    cnt_ff;
   logic [30:0]   inv_ff;

   // Scan.
   logic [WB-1:0]   scan_x_ff;
   logic [HB-1:0]   scan_y_ff;
   logic            scan_act_ff;
   logic signed [EB+15:0] prod_ff [3];
   logic            inside_ff;
   logic [IDXB-1:0] idx_ff;
   logic [MB-1:0]   m_ff;
   logic            neg_ff;
   logic [MB+15:0]  plo_ff;
   logic [MB+14:0]  phi_ff;

   // Clear walk and reset sweep.
   logic [IDXB-1:0] clr_idx_ff, init_idx_ff;
   logic [WB-1:0]   clr_x_ff;
   logic [HB-1:0]   clr_y_ff;

   // Memory port.
   logic                  mem_we, mem_re;
   logic [IDXB-1:0]       mem_waddr, scan_idx;
   logic [DEPTH_BITS-1:0] mem_wdata, mem_rdata;

   // Combinational helpers.
   logic [WB-1:0]          mnx_c, mxx_c;
   logic [HB-1:0]          mny_c, mxy_c;
   logic signed [AB-1:0]   area_c;
   logic [MB+30:0]         full_c;
   logic [MB:0]            zmag_c;
   logic signed [16:0]     z_c;
   logic [15:0]            zb_c;
   logic [DEPTH_BITS-1:0]  key_c;
   logic [16:0]            gin_c;
   logic [24:0]            gprod_c;
   logic [7:0]             gray_c;
   logic signed [EB+17:0]  n_c;
   logic [AB:0]            rem_sh_c;
   logic                   qbit_c;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Effective screen size.
   always_comb begin
      weff = (wdt_ff == '0) ? WB'(1) :
             ((32'(wdt_ff) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(wdt_ff));
      heff = (hgt_ff == '0) ? HB'(1) :
             ((32'(hgt_ff) > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(hgt_ff));
   end

   // Bounding box and area.
   always_comb begin
      mnx_c = sx_ff[0];
      mxx_c = sx_ff[0];
      mny_c = sy_ff[0];
      mxy_c = sy_ff[0];
      for (int k = 1; k < 3; k++) begin
         if (sx_ff[k] < mnx_c) mnx_c = sx_ff[k];
         if (sx_ff[k] > mxx_c) mxx_c = sx_ff[k];
         if (sy_ff[k] < mny_c) mny_c = sy_ff[k];
         if (sy_ff[k] > mxy_c) mxy_c = sy_ff[k];
      end
      if (mxx_c > weff - WB'(1)) mxx_c = weff - WB'(1);
      if (mxy_c > heff - HB'(1)) mxy_c = heff - HB'(1);
      area_c = AB'(cc_ff[0]) + AB'(cc_ff[1]) + AB'(cc_ff[2]);
   end

   // Divider step, depth interpolation end and gray level.
   always_comb begin
      qbit_c   = 1'b0;
      rem_sh_c = {rem_ff[AB-1:0], (cnt_ff == 5'd30)};
      if (rem_sh_c >= {1'b0, dvs_ff}) begin
         qbit_c   = 1'b1;
         rem_sh_c = rem_sh_c - {1'b0, dvs_ff};
      end
      n_c    = (EB+18)'(prod_ff[0]) + (EB+18)'(prod_ff[1]) + (EB+18)'(prod_ff[2]);
      full_c = ((MB+31)'(phi_ff) << 16) + (MB+31)'(plo_ff);
      zmag_c = full_c[MB+30:30];
      if (neg_ff) begin
         z_c = (zmag_c > (MB+1)'(32768)) ? -17'sd32768 : -$signed(17'(zmag_c));
      end else begin
         z_c = (zmag_c > (MB+1)'(32767)) ? 17'sd32767 : $signed(17'(zmag_c));
      end
      zb_c    = 16'(z_c + 17'sd32768);
      key_c   = DEPTH_BITS'((48'(zb_c) << UP) >> DN);
      gin_c   = 17'(18'sd32768 - 18'(z_c));
      gprod_c = (25'(gin_c) << 8) - 25'(gin_c);
      gray_c  = (gprod_c[24:16] > 9'd255) ? 8'd255 : gprod_c[23:16];
   end

   // Memory control.
   always_comb begin
      scan_idx  = IDXB'(32'(scan_y_ff) * MAX_WIDTH + 32'(scan_x_ff));
      mem_re    = (state_ff == ST_SCAN0);
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = key_c;
      case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = init_idx_ff;
            mem_wdata = DEPTH_MAX;
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_ff;
            mem_wdata = DEPTH_MAX;
         end
         ST_SCAN3: mem_we = (key_c < mem_rdata);
         default: ;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:  if (init_idx_ff == LAST_IDX) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               unique case (func_type'(req_data.func))
                  FUNC_LOAD:  state_in = ST_MAPX;
                  FUNC_SCAN:  state_in = scan_act_ff ? ST_SCAN0 : ST_OUT;
                  FUNC_CLEAR: state_in = ST_CLEAR;
                  FUNC_NONE:  state_in = ST_OUT;
                  default:    state_in = ST_OUT;
               endcase
            end
         end
         ST_MAPX:  state_in = ST_MAPY;
         ST_MAPY:  state_in = ST_EDGE;
         ST_EDGE:  state_in = ST_AREA;
         ST_AREA:  state_in = ST_FLIP;
         ST_FLIP:  state_in = (area_ff == '0) ? ST_OUT : ST_ROW;
         ST_ROW:   state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == '0) state_in = ST_OUT;
         ST_SCAN0: state_in = ST_SCAN1;
         ST_SCAN1: state_in = inside_ff ? ST_SCAN2 : ST_OUT;
         ST_SCAN2: state_in = ST_SCAN3;
         ST_SCAN3: state_in = ST_OUT;
         ST_CLEAR: state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         scan_act_ff  <= 1'b0;
         clr_idx_ff   <= '0;
         clr_x_ff     <= '0;
         clr_y_ff     <= '0;
         init_idx_ff  <= '0;
         wdt_ff       <= CSR_SIZE_RESET;
         hgt_ff       <= CSR_SIZE_RESET;
      end else begin
         // Configuration writes.
         if (csr_wen) begin
            unique case (csr_index)
               CSR_SCREEN_WIDTH:  wdt_ff <= csr_wdata;
               CSR_SCREEN_HEIGHT: hgt_ff <= csr_wdata;
               default: ;
            endcase
         end

         // Response register drains when no new response is loaded into it.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_INIT: init_idx_ff <= init_idx_ff + IDXB'(1);

            ST_IDLE: begin
               req_ff                <= req_data;
               res_ff.pixel_x        <= '0;
               res_ff.pixel_y        <= '0;
               res_ff.gray_level     <= '0;
               res_ff.pixel_written  <= 1'b0;
               res_ff.scan_done      <= req_valid && (req_data.func == FUNC_SCAN) &&
                                        !scan_act_ff;
               res_ff.degenerate     <= 1'b0;
               res_ff.clear_done     <= 1'b0;
            end

            // Map x to screen and keep the depths.
            ST_MAPX: begin
               sx_ff[0] <= WB'((32'({~req_ff.vx0[15], req_ff.vx0[14:0]}) * 32'(weff)) >> 16);
               sx_ff[1] <= WB'((32'({~req_ff.vx1[15], req_ff.vx1[14:0]}) * 32'(weff)) >> 16);
               sx_ff[2] <= WB'((32'({~req_ff.vx2[15], req_ff.vx2[14:0]}) * 32'(weff)) >> 16);
               zv_ff[0] <= req_ff.vz0;
               zv_ff[1] <= req_ff.vz1;
               zv_ff[2] <= req_ff.vz2;
            end

            // Map y to screen.
            ST_MAPY: begin
               sy_ff[0] <= HB'((33'(18'sd32768 - 18'(req_ff.vy0)) * 33'(heff)) >> 16);
               sy_ff[1] <= HB'((33'(18'sd32768 - 18'(req_ff.vy1)) * 33'(heff)) >> 16);
               sy_ff[2] <= HB'((33'(18'sd32768 - 18'(req_ff.vy2)) * 33'(heff)) >> 16);
            end

            // Edge coefficients, cross terms and clipped box.
            ST_EDGE: begin
               for (int k = 0; k < 3; k++) begin
                  ea_ff[k] <= $signed((CB+1)'(sy_ff[k])) -
                              $signed((CB+1)'(sy_ff[(k+1)%3]));
                  eb_ff[k] <= $signed((CB+1)'(sx_ff[(k+1)%3])) -
                              $signed((CB+1)'(sx_ff[k]));
                  cc_ff[k] <= $signed(PB'(PB'(sx_ff[k]) * PB'(sy_ff[(k+1)%3]))) -
                              $signed(PB'(PB'(sx_ff[(k+1)%3]) * PB'(sy_ff[k])));
               end
               mnx_ff <= mnx_c;
               mxx_ff <= mxx_c;
               mny_ff <= mny_c;
               mxy_ff <= mxy_c;
               empty_ff <= (mny_c > mxy_c);
            end

            ST_AREA: begin
               area_ff     <= area_c;
               scan_act_ff <= 1'b0;
            end

            // Orientation fix, divider start, or a flat triangle.
            ST_FLIP: begin
               if (area_ff == '0) begin
                  res_ff.degenerate <= 1'b1;
                  res_ff.scan_done  <= 1'b1;
               end else if (area_ff < 0) begin
                  for (int k = 0; k < 3; k++) begin
                     ea_ff[k] <= -ea_ff[k];
                     eb_ff[k] <= -eb_ff[k];
                     cc_ff[k] <= -cc_ff[k];
                  end
               end
               dvs_ff <= (area_ff < 0) ? AB'(-area_ff) : AB'(area_ff);
               rem_ff <= '0;
               quo_ff <= '0;
               cnt_ff <= 5'd30;
            end

            // Edge values at the box corner.
            ST_ROW: begin
               for (int k = 0; k < 3; k++) begin
                  rowv_ff[k] <= EB'(ea_ff[k]) * $signed(EB'(mnx_ff)) +
                                EB'(eb_ff[k]) * $signed(EB'(mny_ff)) + EB'(cc_ff[k]);
                  colv_ff[k] <= EB'(ea_ff[k]) * $signed(EB'(mnx_ff)) +
                                EB'(eb_ff[k]) * $signed(EB'(mny_ff)) + EB'(cc_ff[k]);
               end
               scan_x_ff <= mnx_ff;
               scan_y_ff <= mny_ff;
            end

            // One quotient bit per cycle.
            ST_DIV: begin
               rem_ff <= rem_sh_c;
               quo_ff <= {quo_ff[29:0], qbit_c};
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == '0) begin
                  inv_ff           <= {quo_ff[29:0], qbit_c};
                  scan_act_ff      <= !empty_ff;
                  res_ff.scan_done <= empty_ff;
               end
            end

            // Edge test, depth products and step to the next pixel.
            ST_SCAN0: begin
               inside_ff <= !colv_ff[0][EB-1] && !colv_ff[1][EB-1] && !colv_ff[2][EB-1];
               prod_ff[0] <= colv_ff[1] * (EB+16)'(zv_ff[0]);
               prod_ff[1] <= colv_ff[2] * (EB+16)'(zv_ff[1]);
               prod_ff[2] <= colv_ff[0] * (EB+16)'(zv_ff[2]);
               idx_ff <= scan_idx;
               res_ff.pixel_x <= 8'(scan_x_ff);
               res_ff.pixel_y <= 8'(scan_y_ff);
               if (scan_x_ff < mxx_ff) begin
                  scan_x_ff <= scan_x_ff + WB'(1);
                  for (int k = 0; k < 3; k++) begin
                     colv_ff[k] <= colv_ff[k] + EB'(ea_ff[k]);
                  end
               end else if (scan_y_ff < mxy_ff) begin
                  scan_y_ff <= scan_y_ff + HB'(1);
                  scan_x_ff <= mnx_ff;
                  for (int k = 0; k < 3; k++) begin
                     rowv_ff[k] <= rowv_ff[k] + EB'(eb_ff[k]);
                     colv_ff[k] <= rowv_ff[k] + EB'(eb_ff[k]);
                  end
               end else begin
                  scan_act_ff      <= 1'b0;
                  res_ff.scan_done <= 1'b1;
               end
            end

            ST_SCAN1: begin
               neg_ff <= n_c[EB+17];
               m_ff   <= n_c[EB+17] ? MB'(-n_c) : MB'(n_c);
            end

            // Scale by the inverse area in two halves.
            ST_SCAN2: begin
               plo_ff <= (MB+16)'(m_ff) * (MB+16)'(inv_ff[15:0]);
               phi_ff <= (MB+15)'(m_ff) * (MB+15)'(inv_ff[30:16]);
            end

            // Depth test; the write itself is on the memory port.
            ST_SCAN3: begin
               if (key_c < mem_rdata) begin
                  res_ff.pixel_written <= 1'b1;
                  res_ff.gray_level    <= gray_c;
               end
            end

            // Clear one entry and walk on.
            ST_CLEAR: begin
               res_ff.pixel_x <= 8'(clr_x_ff);
               res_ff.pixel_y <= 8'(clr_y_ff);
               if (clr_idx_ff == LAST_IDX) begin
                  res_ff.clear_done <= 1'b1;
                  clr_idx_ff <= '0;
                  clr_x_ff   <= '0;
                  clr_y_ff   <= '0;
               end else begin
                  clr_idx_ff <= clr_idx_ff + IDXB'(1);
                  if (clr_x_ff == LAST_COL) begin
                     clr_x_ff <= '0;
                     clr_y_ff <= clr_y_ff + HB'(1);
                  end else begin
                     clr_x_ff <= clr_x_ff + WB'(1);
                  end
               end
            end

            // Hand the result to the response register.
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
               end
            end

            default: ;
         endcase
      end
   end

   trz_ram #(
      .WIDTH (DEPTH_BITS),
      .DEPTH (STORE)
   ) u_depth_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (scan_idx),
      .rd_data (mem_rdata)
   );

endmodule

>>> sim/trz_checker.sv
// ----------------------------------------------------------------------------
// Triangle rasteriser checker
// Watches the request, response and register ports of the rasteriser, keeps
// its own model of the edge equations, scan position and depth buffer, and
// compares every accepted response with the oldest predicted one.
// ----------------------------------------------------------------------------
module trz_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  trz_pkg::req_type                   req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  trz_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wen,
   input  logic [trz_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [trz_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                 errors,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import trz_pkg::*;

   localparam int STORE_SIZE = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
   localparam logic [15:0] DEPTH_TOP = 16'hFFFF;

   // Model state.
   logic [15:0]  depth_mem [STORE_SIZE];
   longint       edge_a [3];
   longint       edge_b [3];
   longint       row_val [3];
   longint       col_val [3];
   longint       box_min_x, box_max_x, box_min_y, box_max_y;
   longint       cur_x, cur_y;
   longint       vert_z [3];
   longint       inv_area;
   bit           scanning;
   int           clear_ptr;
   logic [8:0]   width_reg, height_reg;
   rsp_type      expected_q [$];

   function automatic longint mag(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint clamp_size(input logic [8:0] v);
      longint s;
      s = v;
      if (s < 1) s = 1;
      if (s > DEF_MAX_WIDTH) s = DEF_MAX_WIDTH;
      return s;
   endfunction

   task automatic model_reset();
      for (int i = 0; i < STORE_SIZE; i++) depth_mem[i] = DEPTH_TOP;
      for (int k = 0; k < 3; k++) begin
         edge_a[k] = 0; edge_b[k] = 0; row_val[k] = 0; col_val[k] = 0; vert_z[k] = 0;
      end
      box_min_x = 0; box_max_x = 0; box_min_y = 0; box_max_y = 0;
      cur_x = 0; cur_y = 0;
      inv_area = 0;
      scanning = 0;
      clear_ptr = 0;
      width_reg = CSR_SIZE_RESET;
      height_reg = CSR_SIZE_RESET;
   endtask

   // Set up a triangle and return the load response.
   task automatic load_triangle(input req_type r, output rsp_type o);
      longint w, h, area, cst [3], vx [3], vy [3], sx [3], sy [3];
      int b;
      o = '0;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      vx[0] = r.vx0; vy[0] = r.vy0; vert_z[0] = r.vz0;
      vx[1] = r.vx1; vy[1] = r.vy1; vert_z[1] = r.vz1;
      vx[2] = r.vx2; vy[2] = r.vy2; vert_z[2] = r.vz2;
      for (int k = 0; k < 3; k++) begin
         sx[k] = ((vx[k] + 32768) * w) >>> 16;
         sy[k] = ((32768 - vy[k]) * h) >>> 16;
      end
      area = 0;
      for (int k = 0; k < 3; k++) begin
         b = (k + 1) % 3;
         edge_a[k] = sy[k] - sy[b];
         edge_b[k] = sx[b] - sx[k];
         cst[k] = sx[k] * sy[b] - sx[b] * sy[k];
         area += cst[k];
      end
      scanning = 0;
      if (area == 0) begin
         o.degenerate = 1;
         o.scan_done = 1;
         return;
      end
      // A clockwise triangle has all its edges turned round.
      if (area < 0) begin
         for (int k = 0; k < 3; k++) begin
            edge_a[k] = -edge_a[k];
            edge_b[k] = -edge_b[k];
            cst[k] = -cst[k];
         end
      end
      inv_area = (longint'(1) << 30) / mag(area);
      box_min_x = sx[0]; box_max_x = sx[0];
      box_min_y = sy[0]; box_max_y = sy[0];
      for (int k = 1; k < 3; k++) begin
         if (sx[k] < box_min_x) box_min_x = sx[k];
         if (sx[k] > box_max_x) box_max_x = sx[k];
         if (sy[k] < box_min_y) box_min_y = sy[k];
         if (sy[k] > box_max_y) box_max_y = sy[k];
      end
      if (box_max_x > w - 1) box_max_x = w - 1;
      if (box_max_y > h - 1) box_max_y = h - 1;
      if (box_min_x > box_max_x || box_min_y > box_max_y) begin
         o.scan_done = 1;
         return;
      end
      cur_x = box_min_x;
      cur_y = box_min_y;
      for (int k = 0; k < 3; k++) begin
         row_val[k] = edge_a[k] * box_min_x + edge_b[k] * box_min_y + cst[k];
         col_val[k] = row_val[k];
      end
      scanning = 1;
   endtask

   // Visit one pixel of the box with the edge and depth tests.
   task automatic scan_pixel(output rsp_type o);
      longint n, z, g;
      longint unsigned m;
      int idx;
      logic [15:0] key;
      o = '0;
      if (!scanning) begin
         o.scan_done = 1;
         return;
      end
      o.pixel_x = cur_x[7:0];
      o.pixel_y = cur_y[7:0];
      if (col_val[0] >= 0 && col_val[1] >= 0 && col_val[2] >= 0) begin
         n = mag(col_val[1]) * vert_z[0] + mag(col_val[2]) * vert_z[1]
           + mag(col_val[0]) * vert_z[2];
         m = mag(n);
         z = longint'((m * longint'(inv_area)) >> 30);
         if (n < 0) z = -z;
         if (z > 32767) z = 32767;
         if (z < -32768) z = -32768;
         key = 16'(z + 32768);
         idx = int'(cur_y) * DEF_MAX_WIDTH + int'(cur_x);
         if (key < depth_mem[idx]) begin
            g = (255 * (32768 - z)) >>> 16;
            if (g > 255) g = 255;
            depth_mem[idx] = key;
            o.gray_level = g[7:0];
            o.pixel_written = 1;
         end
      end
      if (cur_x < box_max_x) begin
         cur_x++;
         for (int k = 0; k < 3; k++) col_val[k] += edge_a[k];
      end else if (cur_y < box_max_y) begin
         cur_y++;
         cur_x = box_min_x;
         for (int k = 0; k < 3; k++) begin
            row_val[k] += edge_b[k];
            col_val[k] = row_val[k];
         end
      end else begin
         scanning = 0;
         o.scan_done = 1;
      end
   endtask

   // Reset one depth entry and step the clear pointer.
   task automatic clear_entry(output rsp_type o);
      o = '0;
      depth_mem[clear_ptr] = DEPTH_TOP;
      o.pixel_x = 8'(clear_ptr % DEF_MAX_WIDTH);
      o.pixel_y = 8'(clear_ptr / DEF_MAX_WIDTH);
      if (clear_ptr == STORE_SIZE - 1) begin
         o.clear_done = 1;
         clear_ptr = 0;
      end else begin
         clear_ptr++;
      end
   endtask

   task automatic report(input string field, input int got, input int want);
      $display("[%0t] response mismatch on %s: got %0d, expected %0d", $realtime, field,
               got, want);
      errors++;
   endtask

   task automatic compare_rsp(input rsp_type got, input rsp_type want);
      if (got.pixel_x !== want.pixel_x) report("pixel_x", got.pixel_x, want.pixel_x);
      if (got.pixel_y !== want.pixel_y) report("pixel_y", got.pixel_y, want.pixel_y);
      if (got.gray_level !== want.gray_level)
         report("gray_level", got.gray_level, want.gray_level);
      if (got.pixel_written !== want.pixel_written)
         report("pixel_written", got.pixel_written, want.pixel_written);
      if (got.scan_done !== want.scan_done)
         report("scan_done", got.scan_done, want.scan_done);
      if (got.degenerate !== want.degenerate)
         report("degenerate", got.degenerate, want.degenerate);
      if (got.clear_done !== want.clear_done)
         report("clear_done", got.clear_done, want.clear_done);
   endtask

   initial begin
      errors = 0;
      pending = 0;
      model_reset();
   end

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         model_reset();
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("[%0t] response with no request outstanding", $realtime);
               errors++;
            end else begin
               compare_rsp(rsp_data, expected_q.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            want = '0;
            case (func_type'(req_data.func))
               FUNC_LOAD:  load_triangle(req_data, want);
               FUNC_SCAN:  scan_pixel(want);
               FUNC_CLEAR: clear_entry(want);
               default:    want = '0;
            endcase
            expected_q.push_back(want);
         end
         if (csr_wen) begin
            if (csr_index == CSR_SCREEN_WIDTH) width_reg = csr_wdata;
            else if (csr_index == CSR_SCREEN_HEIGHT) height_reg = csr_wdata;
         end
      end
      pending = expected_q.size();
   end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Triangle rasteriser testbench
// Drives loads, pixel scans and depth clears into the rasteriser under
// several screen sizes and idling patterns; a checker beside the block
// predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import trz_pkg::*;

   localparam int WATCHDOG_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      csr_wen;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   int                        errors;
   int                        pending;

   int tx_idle_pct;
   int rx_idle_pct;
   bit hold_request;
   int hold_count;
   int quiet_cycles;
   int width_now;
   int height_now;

   triangle_raster_zbuffer uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   trz_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // The receiver stalls at random, or for a long stretch when asked to.
   initial begin
      rsp_stall = 0;
      hold_count = 0;
      hold_request = 0;
   end
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_count = HOLD_CYCLES;
      end
      if (hold_count > 0) begin
         hold_count--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Ends the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one request and return at the edge where it is taken.
   task automatic send_req(input req_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // The checker updates its count at the edge, so one edge passes first.
   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      wait_drained();
      csr_wen <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 0;
      if (idx == CSR_SCREEN_WIDTH) width_now = val;
      else height_now = val;
   endtask

   function automatic req_type make_op(input func_type f);
      req_type r;
      r = '0;
      r.func = f;
      return r;
   endfunction

   function automatic req_type make_load(input int x0, y0, z0, x1, y1, z1, x2, y2, z2);
      req_type r;
      r = make_op(FUNC_LOAD);
      r.vx0 = 16'(x0); r.vy0 = 16'(y0); r.vz0 = 16'(z0);
      r.vx1 = 16'(x1); r.vy1 = 16'(y1); r.vz1 = 16'(z1);
      r.vx2 = 16'(x2); r.vy2 = 16'(y2); r.vz2 = 16'(z2);
      return r;
   endfunction

   function automatic int near_coord(input int base, input int span);
      int v;
      v = base + int'($urandom_range(span)) - span / 2;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   // Mostly triangles a few pixels across, so that their boxes scan quickly.
   function automatic req_type random_load();
      req_type r;
      int w, h, sx, sy, bx, by;
      r = make_op(FUNC_LOAD);
      r.vz0 = 16'($urandom); r.vz1 = 16'($urandom); r.vz2 = 16'($urandom);
      if ($urandom_range(99) < 15) begin
         r.vx0 = 16'($urandom); r.vy0 = 16'($urandom);
         r.vx1 = 16'($urandom); r.vy1 = 16'($urandom);
         r.vx2 = 16'($urandom); r.vy2 = 16'($urandom);
         return r;
      end
      w = (width_now < 1) ? 1 : (width_now > 256 ? 256 : width_now);
      h = (height_now < 1) ? 1 : (height_now > 256 ? 256 : height_now);
      sx = (8 * 65536) / w; if (sx > 65535) sx = 65535;
      sy = (8 * 65536) / h; if (sy > 65535) sy = 65535;
      bx = int'($urandom_range(65535)) - 32768;
      by = int'($urandom_range(65535)) - 32768;
      r.vx0 = 16'(near_coord(bx, sx)); r.vy0 = 16'(near_coord(by, sy));
      r.vx1 = 16'(near_coord(bx, sx)); r.vy1 = 16'(near_coord(by, sy));
      r.vx2 = 16'(near_coord(bx, sx)); r.vy2 = 16'(near_coord(by, sy));
      return r;
   endfunction

   task automatic random_items(input int count);
      int pick;
      req_type r;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 14) begin
            r = random_load();
         end else if (pick < 88) begin
            r = make_op(FUNC_SCAN);
         end else if (pick < 96) begin
            r = make_op(FUNC_CLEAR);
         end else begin
            // Noise: random selector and payload, the unused code among them.
            r = {$urandom, $urandom, $urandom, $urandom, 18'($urandom)};
            if ($urandom_range(1)) r.func = FUNC_NONE;
         end
         send_req(r);
      end
   endtask

   task automatic directed_items();
      write_csr(CSR_SCREEN_WIDTH, 9'd4);
      write_csr(CSR_SCREEN_HEIGHT, 9'd4);
      // A triangle with its coordinates at the extremes has a box that covers the whole screen.
      send_req(make_load(-32768, 32767, -32768, 32767, 32767, 32767, -32768, -32768, 0));
      repeat (17) send_req(make_op(FUNC_SCAN));
      // The same vertices in the other order give a negative area.
      send_req(make_load(-32768, -32768, 100, 32767, 32767, -5000, -32768, 32767, 32767));
      repeat (4) send_req(make_op(FUNC_SCAN));
      // Zero area: a scan after it has nothing to visit.
      send_req(make_load(1000, 1000, 0, 1000, 1000, 0, 1000, 1000, 0));
      send_req(make_op(FUNC_SCAN));
      // Every vertex on the bottom edge leaves an empty box.
      send_req(make_load(-32768, -32768, 0, 0, -32768, 0, 32767, -32768, 0));
      send_req(make_op(FUNC_CLEAR));
      send_req(make_op(FUNC_NONE));
   endtask

   initial begin
      logic [8:0] sizes [10];
      sizes = '{9'd0, 9'd1, 9'd2, 9'd5, 9'd16, 9'd100, 9'd255, 9'd256, 9'd300, 9'd511};
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_wen = 0;
      csr_index = CSR_SCREEN_WIDTH;
      csr_wdata = '0;
      tx_idle_pct = 17;
      rx_idle_pct = 56;
      quiet_cycles = 0;
      width_now = CSR_SIZE_RESET;
      height_now = CSR_SIZE_RESET;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed_items();

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 17 : (phase == 1 ? 56 : 0);
         rx_idle_pct = (phase == 0) ? 56 : (phase == 1 ? 17 : 0);
         for (int part = 0; part < 4; part++) begin
            write_csr(CSR_SCREEN_WIDTH, sizes[$urandom_range(9)]);
            write_csr(CSR_SCREEN_HEIGHT, sizes[$urandom_range(9)]);
            if (phase == 2 && part == 0) hold_request = 1;
            random_items(25);
            // The sender waits for every response before going on.
            if (part == 1) wait_drained();
            random_items(25);
         end
      end

      // Largest screen to finish.
      write_csr(CSR_SCREEN_WIDTH, 9'd256);
      write_csr(CSR_SCREEN_HEIGHT, 9'd256);
      random_items(30);

      wait_drained();
      repeat (50) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
src/trz_pkg.sv
src/trz_ram.sv
src/triangle_raster_zbuffer.sv
sim/trz_checker.sv
sim/tb.sv
